@@ rtl/debug_port_command_sequencer_assert.svh @@
// ---------------------------------------------------------------------------
// Debug port command sequencer: assertion macros
// Short forms for the concurrent checks written at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef DEBUG_PORT_COMMAND_SEQUENCER_ASSERT_SVH
`define DEBUG_PORT_COMMAND_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DPCS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define DPCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dpcs_pkg.sv @@
// ---------------------------------------------------------------------------
// dpcs_pkg
// Types, codes and the transfer plan of the debug port command sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package dpcs_pkg;

   // Request codes
   localparam logic [4:0] OP_ENTER      = 5'd0;
   localparam logic [4:0] OP_LEAVE      = 5'd1;
   localparam logic [4:0] OP_ERASE      = 5'd2;
   localparam logic [4:0] OP_WRCFG      = 5'd3;
   localparam logic [4:0] OP_RDCFG      = 5'd4;
   localparam logic [4:0] OP_STATUS     = 5'd5;
   localparam logic [4:0] OP_GETPC      = 5'd6;
   localparam logic [4:0] OP_HALT       = 5'd7;
   localparam logic [4:0] OP_RESUME     = 5'd8;
   localparam logic [4:0] OP_STEP       = 5'd9;
   localparam logic [4:0] OP_CHIPID     = 5'd10;
   localparam logic [4:0] OP_DBGINSTR   = 5'd11;
   localparam logic [4:0] OP_SETPC      = 5'd12;
   localparam logic [4:0] OP_IRAM_PEEK  = 5'd13;
   localparam logic [4:0] OP_IRAM_POKE  = 5'd14;
   localparam logic [4:0] OP_XDATA_PEEK = 5'd15;
   localparam logic [4:0] OP_XDATA_POKE = 5'd16;
   localparam logic [4:0] OP_CODE_PEEK  = 5'd17;

   // Transfer kinds
   localparam logic [1:0] KIND_DRIVE  = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_ENTRY  = 2'd2;
   localparam logic [1:0] KIND_RESET  = 2'd3;

   // Debug port command bytes
   localparam logic [7:0] CMD_ERASE    = 8'h14;
   localparam logic [7:0] CMD_WRCFG    = 8'h1D;
   localparam logic [7:0] CMD_RDCFG    = 8'h24;
   localparam logic [7:0] CMD_GETPC    = 8'h28;
   localparam logic [7:0] CMD_STATUS   = 8'h3F;
   localparam logic [7:0] CMD_HALT     = 8'h44;
   localparam logic [7:0] CMD_RESUME   = 8'h4C;
   localparam logic [7:0] CMD_DBGINSTR = 8'h54;
   localparam logic [7:0] CMD_STEP     = 8'h5C;
   localparam logic [7:0] CMD_CHIPID   = 8'h68;

   // 8051 opcodes and operands used by the memory and program counter requests
   localparam logic [7:0] I_LJMP       = 8'h02;
   localparam logic [7:0] I_MOV_A_IMM  = 8'h74;
   localparam logic [7:0] I_MOV_DIR    = 8'h75;
   localparam logic [7:0] I_MOV_DPTR   = 8'h90;
   localparam logic [7:0] I_MOVC_A     = 8'h93;
   localparam logic [7:0] I_MOVX_A_RD  = 8'hE0;
   localparam logic [7:0] I_CLR_A      = 8'hE4;
   localparam logic [7:0] I_MOV_A_DIR  = 8'hE5;
   localparam logic [7:0] I_MOVX_A_WR  = 8'hF0;
   localparam logic [7:0] SFR_MEMCTR   = 8'hC7;
   localparam logic [7:0] HI_MASK      = 8'h7F;

   typedef struct packed {
      logic [4:0]  op;
      logic [16:0] address;
      logic [7:0]  data_a;
      logic [7:0]  data_b;
      logic [7:0]  data_c;
      logic [1:0]  instr_len;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] wire_byte;
      logic       reply_kept;
      logic       last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic issue;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic op_known;
      logic slot_free;
      logic plan_last;
   } ctl_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } seq_state_type;

   // One transfer of a debug instruction: command byte, len bytes, one sample
   function automatic rsp_type dbg_xfer(input logic [1:0] len, input logic [7:0] a,
                                        input logic [7:0] b, input logic [7:0] c,
                                        input logic kept, input logic [4:0] pos,
                                        input logic fin);
      rsp_type    x;
      logic [4:0] len_w;
      len_w = {3'b000, len};
      x = '0;
      priority if (pos == 5'd0) begin
         x.kind      = KIND_DRIVE;
         x.wire_byte = CMD_DBGINSTR + {6'b000000, len};
      end else if (pos <= len_w) begin
         x.kind = KIND_DRIVE;
         priority if (pos == 5'd1) begin
            x.wire_byte = a;
         end else if (pos == 5'd2) begin
            x.wire_byte = b;
         end else begin
            x.wire_byte = c;
         end
      end else begin
         x.kind       = KIND_SAMPLE;
         x.reply_kept = kept;
         x.last       = fin;
      end
      return x;
   endfunction

   // One transfer of a simple command: command byte then kept samples
   function automatic rsp_type cmd_xfer(input logic [7:0] code, input logic [1:0] replies,
                                        input logic [4:0] pos);
      rsp_type x;
      x = '0;
      if (pos == 5'd0) begin
         x.kind      = KIND_DRIVE;
         x.wire_byte = code;
      end else begin
         x.kind       = KIND_SAMPLE;
         x.reply_kept = 1'b1;
         x.last       = (pos == {3'b000, replies});
      end
      return x;
   endfunction

   // Transfer number idx of the run that carries request r
   function automatic rsp_type plan_xfer(input req_type r, input logic [4:0] idx);
      rsp_type    x;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] bank_sel;
      hi       = r.address[15:8];
      lo       = r.address[7:0];
      bank_sel = {2'b00, r.address[16:15], 4'b0001};
      x        = '0;
      unique case (r.op)
         OP_ENTER: begin
            x.kind = KIND_ENTRY;
            x.last = 1'b1;
         end
         OP_LEAVE: begin
            x.kind = KIND_RESET;
            x.last = 1'b1;
         end
         OP_ERASE:  x = cmd_xfer(CMD_ERASE, 2'd1, idx);
         OP_RDCFG:  x = cmd_xfer(CMD_RDCFG, 2'd1, idx);
         OP_STATUS: x = cmd_xfer(CMD_STATUS, 2'd1, idx);
         OP_GETPC:  x = cmd_xfer(CMD_GETPC, 2'd2, idx);
         OP_HALT:   x = cmd_xfer(CMD_HALT, 2'd1, idx);
         OP_RESUME: x = cmd_xfer(CMD_RESUME, 2'd1, idx);
         OP_STEP:   x = cmd_xfer(CMD_STEP, 2'd1, idx);
         OP_CHIPID: x = cmd_xfer(CMD_CHIPID, 2'd2, idx);
         OP_WRCFG: begin
            priority if (idx == 5'd0) begin
               x.kind      = KIND_DRIVE;
               x.wire_byte = CMD_WRCFG;
            end else if (idx == 5'd1) begin
               x.kind      = KIND_DRIVE;
               x.wire_byte = r.data_a;
            end else begin
               x.kind       = KIND_SAMPLE;
               x.reply_kept = 1'b1;
               x.last       = 1'b1;
            end
         end
         OP_DBGINSTR:
            x = dbg_xfer(r.instr_len, r.data_a, r.data_b, r.data_c, 1'b1, idx, 1'b1);
         OP_SETPC:
            x = dbg_xfer(2'd3, I_LJMP, hi, lo, 1'b0, idx, 1'b1);
         OP_IRAM_PEEK: begin
            if (idx < 5'd4) x = dbg_xfer(2'd2, I_CLR_A, 8'h00, 8'h00, 1'b0, idx, 1'b0);
            else x = dbg_xfer(2'd3, I_MOV_A_DIR, lo, 8'h00, 1'b1, idx - 5'd4, 1'b1);
         end
         OP_IRAM_POKE: begin
            if (idx < 5'd4) x = dbg_xfer(2'd2, I_CLR_A, 8'h00, 8'h00, 1'b0, idx, 1'b0);
            else x = dbg_xfer(2'd3, I_MOV_DIR, lo, r.data_a, 1'b0, idx - 5'd4, 1'b1);
         end
         OP_XDATA_PEEK: begin
            if (idx < 5'd5) x = dbg_xfer(2'd3, I_MOV_DPTR, hi, lo, 1'b0, idx, 1'b0);
            else x = dbg_xfer(2'd3, I_MOVX_A_RD, 8'h00, 8'h00, 1'b1, idx - 5'd5, 1'b1);
         end
         OP_XDATA_POKE: begin
            priority if (idx < 5'd5) begin
               x = dbg_xfer(2'd3, I_MOV_DPTR, hi, lo, 1'b0, idx, 1'b0);
            end else if (idx < 5'd9) begin
               x = dbg_xfer(2'd2, I_MOV_A_IMM, r.data_a, 8'h00, 1'b0, idx - 5'd5, 1'b0);
            end else begin
               x = dbg_xfer(2'd1, I_MOVX_A_WR, 8'h00, 8'h00, 1'b0, idx - 5'd9, 1'b1);
            end
         end
         OP_CODE_PEEK: begin
            priority if (idx < 5'd5) begin
               x = dbg_xfer(2'd3, I_MOV_DIR, SFR_MEMCTR, bank_sel, 1'b0, idx, 1'b0);
            end else if (idx < 5'd10) begin
               x = dbg_xfer(2'd3, I_MOV_DPTR, hi & HI_MASK, lo, 1'b0, idx - 5'd5, 1'b0);
            end else if (idx < 5'd14) begin
               x = dbg_xfer(2'd2, I_CLR_A, 8'h00, 8'h00, 1'b0, idx - 5'd10, 1'b0);
            end else begin
               x = dbg_xfer(2'd3, I_MOVC_A, 8'h00, 8'h00, 1'b1, idx - 5'd14, 1'b1);
            end
         end
         default: x = '0;
      endcase
      return x;
   endfunction

endpackage

`default_nettype wire

@@ rtl/debug_port_command_sequencer.sv @@
// ---------------------------------------------------------------------------
// debug_port_command_sequencer
// Turns one host debug request into the run of two-wire debug port transfers.
// ---------------------------------------------------------------------------
// A request is taken when the block is idle and comes out as one transfer
// per rsp_ handshake, the last one flagged. The request is first captured,
// then the step counter of the sequencer gives one transfer per cycle while
// the result slot is free, so the banked code peek gives 19 transfers. An
// unknown request code is dropped in the cycle it arrives and gives no
// transfers. The last transfer may still wait in the result register while
// the next request is taken.
`default_nettype none

`include "debug_port_command_sequencer_assert.svh"

module debug_port_command_sequencer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire dpcs_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output dpcs_pkg::rsp_type       rsp_data
);

   dpcs_pkg::ctl_cmd_type    cmd;
   dpcs_pkg::ctl_status_type status;

   dpcs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dpcs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A transfer only goes into a free result slot
   `DPCS_ASSERT_NOW(a_issue_free, clock, reset, cmd.issue, status.slot_free, "issue into full slot")
   // A captured request blocks the next one
   `DPCS_ASSERT_NEXT(a_load_busy, clock, reset, cmd.load, req_stall, "request taken while busy")
   // The last transfer returns the sequencer to idle
   `DPCS_ASSERT_NEXT(a_last_idle, clock, reset, cmd.issue && status.plan_last, !req_stall, "no idle after last")
   // An issued transfer shows up in the result register
   `DPCS_ASSERT_NEXT(a_issue_out, clock, reset, cmd.issue, rsp_valid, "issued transfer missing")

endmodule

`default_nettype wire

@@ rtl/dpcs_datapath.sv @@
// ---------------------------------------------------------------------------
// dpcs_datapath
// Request register, transfer counter, plan lookup and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module dpcs_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dpcs_pkg::req_type         req_data,
   input  wire dpcs_pkg::ctl_cmd_type     cmd,
   output dpcs_pkg::ctl_status_type       status,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output dpcs_pkg::rsp_type              rsp_data
);

   dpcs_pkg::req_type req_ff;
   dpcs_pkg::req_type req_in;
   logic [4:0]        step_ff;
   logic [4:0]        step_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   dpcs_pkg::rsp_type rsp_ff;
   dpcs_pkg::rsp_type rsp_in;
   dpcs_pkg::rsp_type plan;

   // Look up the current transfer of the held request
   always_comb begin
      plan = dpcs_pkg::plan_xfer(req_ff, step_ff);
   end

   // Report to the controller
   always_comb begin
      status.op_known  = (req_data.op <= dpcs_pkg::OP_CODE_PEEK);
      status.slot_free = !rsp_valid_ff || !rsp_stall;
      status.plan_last = plan.last;
   end

   // Capture request, advance the transfer counter, load the result slot
   always_comb begin
      req_in       = cmd.load ? req_data : req_ff;
      step_in      = step_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         step_in = 5'd0;
      end else if (cmd.issue) begin
         step_in = step_ff + 5'd1;
      end
      if (cmd.issue) begin
         rsp_in       = plan;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload holds without reset
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/dpcs_controller.sv @@
// ---------------------------------------------------------------------------
// dpcs_controller
// State machine that takes a request and steps the datapath through its run.
// ---------------------------------------------------------------------------
`default_nettype none

module dpcs_controller (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire dpcs_pkg::ctl_status_type  status,
   output dpcs_pkg::ctl_cmd_type          cmd
);

   dpcs_pkg::seq_state_type state_ff;
   dpcs_pkg::seq_state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dpcs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pick next state and drive datapath commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         dpcs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            // drop unknown requests, start a run for the rest
            if (req_valid && status.op_known) begin
               cmd.load = 1'b1;
               state_in = dpcs_pkg::ST_RUN;
            end
         end
         dpcs_pkg::ST_RUN: begin
            if (status.slot_free) begin
               cmd.issue = 1'b1;
               if (status.plan_last) begin
                  state_in = dpcs_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = dpcs_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Testbench of the debug port command sequencer: drives host debug requests
// through a directed table and then random requests, and checks every wire
// transfer that comes back against a predictor of the transfer runs or a pinned transfer.
// ---------------------------------------------------------------------------

module tb_top;

   localparam int CLOCK_HALF       = 10;
   localparam int RESET_CYCLES     = 5;
   localparam int RANDOM_REQUESTS  = 283;
   localparam int DRAIN_AT         = 150;
   localparam int LONG_HOLD_AT     = 250;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 40;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int REPORT_LIMIT     = 10;

   localparam logic [4:0] OP_UNKNOWN_LOW  = 5'd18;
   localparam logic [4:0] OP_UNKNOWN_HIGH = 5'd31;

   // How the transfers of a table row are known
   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_SINGLE,
      CHECK_SILENT
   } check_mode_type;

   typedef struct {
      dpcs_pkg::req_type request;
      check_mode_type    mode;
      dpcs_pkg::rsp_type pinned;
   } table_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   dpcs_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   dpcs_pkg::rsp_type rsp_data;

   dpcs_pkg::rsp_type pending_xfers[$];
   dpcs_pkg::rsp_type run_q[$];
   table_row_type     directed_rows[$];
   int                fault_count = 0;
   int                cycle_count = 0;

   debug_port_command_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Transfer run predictor
   // ------------------------------------------------------------------
   function automatic void add_xfer(input logic [1:0] kind, input logic [7:0] wbyte,
                                    input logic kept);
      dpcs_pkg::rsp_type x;
      x = {kind, wbyte, kept, 1'b0};
      run_q.push_back(x);
   endfunction

   // Debug instruction: command byte with length, operand bytes, one sample
   function automatic void add_instr(input logic [1:0] len, input logic [7:0] a,
                                     input logic [7:0] b, input logic [7:0] c,
                                     input logic kept);
      add_xfer(dpcs_pkg::KIND_DRIVE, dpcs_pkg::CMD_DBGINSTR + {6'b000000, len}, 1'b0);
      if (len > 2'd0) add_xfer(dpcs_pkg::KIND_DRIVE, a, 1'b0);
      if (len > 2'd1) add_xfer(dpcs_pkg::KIND_DRIVE, b, 1'b0);
      if (len > 2'd2) add_xfer(dpcs_pkg::KIND_DRIVE, c, 1'b0);
      add_xfer(dpcs_pkg::KIND_SAMPLE, 8'h00, kept);
   endfunction

   function automatic void add_command(input logic [7:0] code, input int replies);
      add_xfer(dpcs_pkg::KIND_DRIVE, code, 1'b0);
      for (int i = 0; i < replies; i++) add_xfer(dpcs_pkg::KIND_SAMPLE, 8'h00, 1'b1);
   endfunction

   // Append the whole run of transfers of one request, last one marked
   function automatic void plan_transfers(input dpcs_pkg::req_type r);
      logic [7:0]        hi;
      logic [7:0]        lo;
      logic [7:0]        bank_sel;
      dpcs_pkg::rsp_type tail;
      hi       = r.address[15:8];
      lo       = r.address[7:0];
      bank_sel = {2'b00, r.address[16:15], 4'b0001};
      run_q    = {};
      case (r.op)
         dpcs_pkg::OP_ENTER:  add_xfer(dpcs_pkg::KIND_ENTRY, 8'h00, 1'b0);
         dpcs_pkg::OP_LEAVE:  add_xfer(dpcs_pkg::KIND_RESET, 8'h00, 1'b0);
         dpcs_pkg::OP_ERASE:  add_command(dpcs_pkg::CMD_ERASE, 1);
         dpcs_pkg::OP_WRCFG: begin
            add_xfer(dpcs_pkg::KIND_DRIVE, dpcs_pkg::CMD_WRCFG, 1'b0);
            add_xfer(dpcs_pkg::KIND_DRIVE, r.data_a, 1'b0);
            add_xfer(dpcs_pkg::KIND_SAMPLE, 8'h00, 1'b1);
         end
         dpcs_pkg::OP_RDCFG:  add_command(dpcs_pkg::CMD_RDCFG, 1);
         dpcs_pkg::OP_STATUS: add_command(dpcs_pkg::CMD_STATUS, 1);
         dpcs_pkg::OP_GETPC:  add_command(dpcs_pkg::CMD_GETPC, 2);
         dpcs_pkg::OP_HALT:   add_command(dpcs_pkg::CMD_HALT, 1);
         dpcs_pkg::OP_RESUME: add_command(dpcs_pkg::CMD_RESUME, 1);
         dpcs_pkg::OP_STEP:   add_command(dpcs_pkg::CMD_STEP, 1);
         dpcs_pkg::OP_CHIPID: add_command(dpcs_pkg::CMD_CHIPID, 2);
         dpcs_pkg::OP_DBGINSTR:
            add_instr(r.instr_len, r.data_a, r.data_b, r.data_c, 1'b1);
         dpcs_pkg::OP_SETPC:  add_instr(2'd3, dpcs_pkg::I_LJMP, hi, lo, 1'b0);
         dpcs_pkg::OP_IRAM_PEEK: begin
            add_instr(2'd2, dpcs_pkg::I_CLR_A, 8'h00, 8'h00, 1'b0);
            add_instr(2'd3, dpcs_pkg::I_MOV_A_DIR, lo, 8'h00, 1'b1);
         end
         dpcs_pkg::OP_IRAM_POKE: begin
            add_instr(2'd2, dpcs_pkg::I_CLR_A, 8'h00, 8'h00, 1'b0);
            add_instr(2'd3, dpcs_pkg::I_MOV_DIR, lo, r.data_a, 1'b0);
         end
         dpcs_pkg::OP_XDATA_PEEK: begin
            add_instr(2'd3, dpcs_pkg::I_MOV_DPTR, hi, lo, 1'b0);
            add_instr(2'd3, dpcs_pkg::I_MOVX_A_RD, 8'h00, 8'h00, 1'b1);
         end
         dpcs_pkg::OP_XDATA_POKE: begin
            add_instr(2'd3, dpcs_pkg::I_MOV_DPTR, hi, lo, 1'b0);
            add_instr(2'd2, dpcs_pkg::I_MOV_A_IMM, r.data_a, 8'h00, 1'b0);
            add_instr(2'd1, dpcs_pkg::I_MOVX_A_WR, 8'h00, 8'h00, 1'b0);
         end
         dpcs_pkg::OP_CODE_PEEK: begin
            add_instr(2'd3, dpcs_pkg::I_MOV_DIR, dpcs_pkg::SFR_MEMCTR, bank_sel, 1'b0);
            add_instr(2'd3, dpcs_pkg::I_MOV_DPTR, hi & dpcs_pkg::HI_MASK, lo, 1'b0);
            add_instr(2'd2, dpcs_pkg::I_CLR_A, 8'h00, 8'h00, 1'b0);
            add_instr(2'd3, dpcs_pkg::I_MOVC_A, 8'h00, 8'h00, 1'b1);
         end
         default: ;
      endcase
      if (run_q.size() > 0) begin
         tail      = run_q[run_q.size() - 1];
         tail.last = 1'b1;
         run_q[run_q.size() - 1] = tail;
      end
      foreach (run_q[i]) pending_xfers.push_back(run_q[i]);
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   task automatic add_row(input logic [4:0] op, input logic [16:0] address,
                          input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                          input logic [1:0] len, input check_mode_type mode,
                          input dpcs_pkg::rsp_type pinned);
      table_row_type row;
      row.request.op        = op;
      row.request.address   = address;
      row.request.data_a    = a;
      row.request.data_b    = b;
      row.request.data_c    = c;
      row.request.instr_len = len;
      row.mode              = mode;
      row.pinned            = pinned;
      directed_rows.push_back(row);
   endtask

   // Offer one request, hold it until taken, queue its transfers, then idle for the gap if any
   task automatic offer(input dpcs_pkg::req_type r, input check_mode_type mode,
                        input dpcs_pkg::rsp_type pinned, input int gap);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (mode == CHECK_SINGLE) pending_xfers.push_back(pinned);
      else if (mode == CHECK_MODEL) plan_transfers(r);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every queued transfer has come back
   task automatic drain_requests();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_xfers.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      dpcs_pkg::req_type r;
      int                gap;
      int                n;
      logic              calm;
      dpcs_pkg::rsp_type none;
      none = '0;

      // Directed table: extremes, every request, unknown codes
      add_row(dpcs_pkg::OP_ENTER, 17'h1FFFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, CHECK_SINGLE,
              {dpcs_pkg::KIND_ENTRY, 8'h00, 1'b0, 1'b1});
      add_row(dpcs_pkg::OP_LEAVE, 17'h00000, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_SINGLE,
              {dpcs_pkg::KIND_RESET, 8'h00, 1'b0, 1'b1});
      add_row(dpcs_pkg::OP_ERASE, 17'h00000, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_MODEL, none);
      add_row(dpcs_pkg::OP_WRCFG, 17'h00000, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_MODEL, none);
      add_row(dpcs_pkg::OP_WRCFG, 17'h1FFFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, CHECK_MODEL, none);
      add_row(dpcs_pkg::OP_RDCFG, 17'h00000, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_MODEL, none);
      add_row(dpcs_pkg::OP_STATUS, 17'h1FFFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, CHECK_MODEL, none);
      add_row(dpcs_pkg::OP_GETPC, 17'h00000, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_MODEL, none);
      add_row(dpcs_pkg::OP_HALT, 17'h00000, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_MODEL, none);
      add_row(dpcs_pkg::OP_RESUME, 17'h00000, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_MODEL, none);
      add_row(dpcs_pkg::OP_STEP, 17'h00000, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_MODEL, none);
      add_row(dpcs_pkg::OP_CHIPID, 17'h1FFFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, CHECK_MODEL, none);
      add_row(dpcs_pkg::OP_DBGINSTR, 17'h00000, 8'hFF, 8'hFF, 8'hFF, 2'd0, CHECK_MODEL,
              none);
      add_row(dpcs_pkg::OP_DBGINSTR, 17'h00000, 8'hA5, 8'h5A, 8'h3C, 2'd1, CHECK_MODEL,
              none);
      add_row(dpcs_pkg::OP_DBGINSTR, 17'h00000, 8'h00, 8'hFF, 8'h00, 2'd2, CHECK_MODEL,
              none);
      add_row(dpcs_pkg::OP_DBGINSTR, 17'h00000, 8'hFF, 8'hFF, 8'hFF, 2'd3, CHECK_MODEL,
              none);
      add_row(dpcs_pkg::OP_SETPC, 17'h1FFFF, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_MODEL, none);
      add_row(dpcs_pkg::OP_SETPC, 17'h00000, 8'hFF, 8'hFF, 8'hFF, 2'd3, CHECK_MODEL, none);
      add_row(dpcs_pkg::OP_IRAM_PEEK, 17'h1FFFF, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_MODEL,
              none);
      add_row(dpcs_pkg::OP_IRAM_POKE, 17'h00000, 8'hFF, 8'h00, 8'h00, 2'd0, CHECK_MODEL,
              none);
      add_row(dpcs_pkg::OP_XDATA_PEEK, 17'h0FFFF, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_MODEL,
              none);
      add_row(dpcs_pkg::OP_XDATA_POKE, 17'h1FFFF, 8'h00, 8'hFF, 8'hFF, 2'd3, CHECK_MODEL,
              none);
      add_row(dpcs_pkg::OP_CODE_PEEK, 17'h1FFFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, CHECK_MODEL,
              none);
      add_row(dpcs_pkg::OP_CODE_PEEK, 17'h08000, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_MODEL,
              none);
      add_row(OP_UNKNOWN_LOW, 17'h00000, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_SILENT, none);
      add_row(OP_UNKNOWN_HIGH, 17'h1FFFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, CHECK_SILENT, none);
      add_row(dpcs_pkg::OP_ENTER, 17'h00000, 8'h00, 8'h00, 8'h00, 2'd0, CHECK_SINGLE,
              {dpcs_pkg::KIND_ENTRY, 8'h00, 1'b0, 1'b1});

      // Hold reset, then release it at a clock edge
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      n = 0;
      foreach (directed_rows[i]) begin
         gap = (i % 7 == 3) ? 0 : $urandom_range(0, 15);
         offer(directed_rows[i].request, directed_rows[i].mode, directed_rows[i].pinned, gap);
      end

      // Random requests with unknown codes mixed in
      while (n < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 9) == 0) begin
            r.op = 5'($urandom_range(OP_UNKNOWN_LOW, OP_UNKNOWN_HIGH));
         end else begin
            r.op = 5'($urandom_range(dpcs_pkg::OP_ENTER, dpcs_pkg::OP_CODE_PEEK));
         end
         r.address   = 17'($urandom_range(0, 17'h1FFFF));
         r.data_a    = 8'($urandom_range(0, 255));
         r.data_b    = 8'($urandom_range(0, 255));
         r.data_c    = 8'($urandom_range(0, 255));
         r.instr_len = 2'($urandom_range(0, 3));
         calm = ((n / 40) % 3) == 1;
         gap  = calm ? 0 : $urandom_range(0, 15);
         offer(r, CHECK_MODEL, none, gap);
         n++;
         if (n == DRAIN_AT) drain_requests();
      end

      // Let every transfer arrive, then watch for stray ones
      drain_requests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("PASS debug_port_command_sequencer");
      end else begin
         $display("FAIL debug_port_command_sequencer");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Result side: random stalls, calm stretches and one long hold-off
   // ------------------------------------------------------------------
   initial begin : result_side
      int hold;
      int taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
         else if (((taken / 64) % 3) == 1) hold = 0;
         else hold = $urandom_range(0, 15);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   // ------------------------------------------------------------------
   // Compare each transfer taken with the oldest one predicted
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      dpcs_pkg::rsp_type want;
      logic              bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_xfers.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected transfer: kind %0d byte %h kept %b last %b",
                        rsp_data.kind, rsp_data.wire_byte, rsp_data.reply_kept,
                        rsp_data.last);
         end else begin
            want = pending_xfers.pop_front();
            bad  = 1'b0;
            if (rsp_data.kind !== want.kind) bad = 1'b1;
            if (rsp_data.wire_byte !== want.wire_byte) bad = 1'b1;
            if (rsp_data.reply_kept !== want.reply_kept) bad = 1'b1;
            if (rsp_data.last !== want.last) bad = 1'b1;
            if (bad) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("transfer mismatch: expected kind %0d byte %h kept %b last %b, %s",
                           want.kind, want.wire_byte, want.reply_kept, want.last,
                           $sformatf("got kind %0d byte %h kept %b last %b",
                                     rsp_data.kind, rsp_data.wire_byte,
                                     rsp_data.reply_kept, rsp_data.last));
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL debug_port_command_sequencer");
         $finish;
      end
   end

endmodule
